/* hw/rtl/lpfs_pkg.sv */
package lpfs_pkg;

  // Frame header: length, method and method type, each a big-endian 32-bit word.
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned HDR_IDX_W    = 4;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned MAX_LEN_W    = 31;

  // Header byte positions at which the length and method words are complete.
  localparam logic [HDR_IDX_W-1:0] HDR_LEN_END  = HDR_IDX_W'(4);
  localparam logic [HDR_IDX_W-1:0] HDR_METH_END = HDR_IDX_W'(8);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST     = HDR_IDX_W'(HEADER_BYTES - 1);

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(65536);

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_BAD_LEN = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] method_code;
    logic signed [31:0] method_kind;
    logic signed [31:0] frame_length;
    logic [7:0]         payload_byte;
    logic               first_of_frame;
    logic               last_of_frame;
  } item_t;

endpackage

/* hw/rtl/length_prefixed_frame_splitter_top.sv */
// Path: a payload byte, or the closing byte of an empty or rejected header, is written into the
//   queue on the edge that accepts it; the queue then loads it into the output register, from
//   which the result channel offers it, once that register is free or is being emptied.
// Throughput: one byte per cycle while the queue has room; the front updates its header/counter state per byte.
// The queue holds QUEUE_DEPTH results; the input stalls whenever the queue is full.
// Reset (rst_n, synchronous, active low) returns to header collection, empties the queue
//   and sets the maximum frame length to 65536.
module length_prefixed_frame_splitter_top #(
  parameter int unsigned QUEUE_DEPTH = lpfs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Byte stream in.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  // Results out.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] method_code, [63:32] method_kind, [95:64] frame_length, [103:96] payload_byte
  output logic [103:0]                      out_tdata,
  output logic [2:0]                        out_tuser,  // [1:0] kind, [2] first_of_frame
  output logic                              out_tlast,  // last_of_frame
  // Maximum frame length register.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lpfs_pkg::MAX_LEN_W-1:0]    cfg_data
);

  // The maximum frame length is checked once per header, on its final byte.
  logic [lpfs_pkg::MAX_LEN_W-1:0] max_len_r;
  logic                           queue_can_push;
  logic                           push;
  lpfs_pkg::item_t                push_item;
  lpfs_pkg::item_t                out_item;

  // Always writable; software must write it only when the block is idle; the block does not enforce this.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= lpfs_pkg::MAX_LEN_RESET;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  // A byte is taken whenever the queue has room, whether or not it will yield a result.
  assign in_tready = queue_can_push;

  // Front: header collection, length check and payload counting.
  lpfs_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_data     (in_tdata),
    .queue_ready (queue_can_push),
    .max_len     (max_len_r),
    .push        (push),
    .push_item   (push_item)
  );

  // Back: result queue and the output register that drives the result channel.
  lpfs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .can_push  (queue_can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {out_item.payload_byte, out_item.frame_length,
                      out_item.method_kind, out_item.method_code};
  assign out_tuser = {out_item.first_of_frame, out_item.kind};
  assign out_tlast = out_item.last_of_frame;

endmodule

/* hw/rtl/lpfs_front.sv */
module lpfs_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic [7:0]                          in_data,
  input  logic                                queue_ready,
  input  logic [lpfs_pkg::MAX_LEN_W-1:0]      max_len,
  output logic                                push,
  output lpfs_pkg::item_t                     push_item
);

  logic                                in_payload_r, in_payload_nxt;
  logic [lpfs_pkg::HDR_IDX_W-1:0]      hdr_idx_r, hdr_idx_nxt;
  logic [lpfs_pkg::WORD_W-1:0]         len_r, len_nxt;
  logic [lpfs_pkg::WORD_W-1:0]         meth_r, meth_nxt;
  logic [lpfs_pkg::WORD_W-1:0]         type_r, type_nxt;
  logic [lpfs_pkg::MAX_LEN_W-1:0]      remain_r, remain_nxt;
  logic                                first_r, first_nxt;
  logic                                fire;
  logic                                last_byte;
  logic                                bad_len;
  logic                                empty_frame;

  assign fire        = in_valid && queue_ready;
  assign last_byte   = (remain_r <= lpfs_pkg::MAX_LEN_W'(1));
  assign bad_len     = len_r[lpfs_pkg::WORD_W-1] ||
                       (len_r < lpfs_pkg::WORD_W'(lpfs_pkg::HEADER_BYTES)) ||
                       (len_r > {1'b0, max_len});
  assign empty_frame = (len_r == lpfs_pkg::WORD_W'(lpfs_pkg::HEADER_BYTES));

  always_comb begin
    in_payload_nxt = in_payload_r;
    hdr_idx_nxt    = hdr_idx_r;
    len_nxt        = len_r;
    meth_nxt       = meth_r;
    type_nxt       = type_r;
    remain_nxt     = remain_r;
    first_nxt      = first_r;
    push           = 1'b0;
    push_item.kind           = lpfs_pkg::KIND_PAYLOAD;
    push_item.payload_byte   = 8'd0;
    push_item.first_of_frame = 1'b0;
    push_item.last_of_frame  = 1'b1;
    if (fire) begin
      if (in_payload_r) begin
        push                     = 1'b1;
        push_item.payload_byte   = in_data;
        push_item.first_of_frame = first_r;
        push_item.last_of_frame  = last_byte;
        first_nxt                = 1'b0;
        if (last_byte) begin
          in_payload_nxt = 1'b0;
        end else begin
          remain_nxt = remain_r - lpfs_pkg::MAX_LEN_W'(1);
        end
      end else begin
        if (hdr_idx_r < lpfs_pkg::HDR_LEN_END) begin
          len_nxt = {len_r[lpfs_pkg::WORD_W-9:0], in_data};
        end else if (hdr_idx_r < lpfs_pkg::HDR_METH_END) begin
          meth_nxt = {meth_r[lpfs_pkg::WORD_W-9:0], in_data};
        end else begin
          type_nxt = {type_r[lpfs_pkg::WORD_W-9:0], in_data};
        end
        if (hdr_idx_r == lpfs_pkg::HDR_LAST) begin
          // Header complete: the length word has been whole since byte four.
          hdr_idx_nxt = '0;
          if (bad_len) begin
            push           = 1'b1;
            push_item.kind = lpfs_pkg::KIND_BAD_LEN;
          end else if (empty_frame) begin
            push           = 1'b1;
            push_item.kind = lpfs_pkg::KIND_EMPTY;
          end else begin
            in_payload_nxt = 1'b1;
            first_nxt      = 1'b1;
            remain_nxt     = lpfs_pkg::MAX_LEN_W'(len_r -
                             lpfs_pkg::WORD_W'(lpfs_pkg::HEADER_BYTES));
          end
        end else begin
          hdr_idx_nxt = hdr_idx_r + lpfs_pkg::HDR_IDX_W'(1);
        end
      end
    end
    push_item.method_code  = meth_nxt;
    push_item.method_kind  = type_nxt;
    push_item.frame_length = len_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      hdr_idx_r    <= '0;
      first_r      <= 1'b0;
    end else begin
      in_payload_r <= in_payload_nxt;
      hdr_idx_r    <= hdr_idx_nxt;
      first_r      <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    meth_r   <= meth_nxt;
    type_r   <= type_nxt;
    remain_r <= remain_nxt;
  end

  // A frame in progress always has at least one payload byte still to come.
  a_remain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload_r |-> (remain_r != '0))
    else $error("payload counter empty inside a frame");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_idx_r <= lpfs_pkg::HDR_LAST)
    else $error("header index past the header");

  // The first-byte mark lives only inside a frame and never during header collection.
  a_first_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    first_r |-> (in_payload_r && (hdr_idx_r == '0)))
    else $error("first mark outside a frame");

endmodule

/* hw/rtl/lpfs_queue.sv */
module lpfs_queue #(
  parameter int unsigned DEPTH = lpfs_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lpfs_pkg::item_t push_item,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_ready,
  output lpfs_pkg::item_t out_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  lpfs_pkg::item_t mem [DEPTH];
  lpfs_pkg::item_t out_item_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             pop;

  assign can_push  = (count_r < CNT_W'(DEPTH));
  assign pop       = (count_r != '0) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
    if (pop) begin
      out_item_r <= mem[rd_ptr_r];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");

  // A held result that is not taken stays valid on the next cycle.
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r)
    else $error("output result dropped before being taken");

endmodule
